>>> rtl/core/dtaw_pkg.sv
// ----------------------------------------------------------------------------
// dtaw_pkg
// Shared types and constants for the delay-threshold AIMD window block.
// ----------------------------------------------------------------------------
`default_nettype none

package dtaw_pkg;

    // default parameter values
    localparam int TIME_BITS_DEF        = 32;
    localparam int WINDOW_FRAC_BITS_DEF = 16;

    // RTT estimate is Q32.8
    localparam int RTT_FRAC   = 8;
    localparam int RTT_W      = 32 + RTT_FRAC;

    // EWMA product: 18-bit weight, two bits per step
    localparam int EWMA_STEPS = 9;
    localparam int ACC_W      = 60;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // configuration register reset values
    localparam logic [15:0] RTT_THRESHOLD_RST = 16'd110;
    localparam logic [15:0] HOLDOFF_RST       = 16'd500;
    localparam logic [16:0] EWMA_WEIGHT_RST   = 17'd6554;
    localparam logic [16:0] DEC_FACTOR_RST    = 17'd32768;
    localparam logic [16:0] ONE_Q16           = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RTT_THRESHOLD = 3'd0,
        REG_HOLDOFF       = 3'd1,
        REG_EWMA_WEIGHT   = 3'd2,
        REG_DEC_FACTOR    = 3'd3,
        REG_MIN_WINDOW    = 3'd4
    } dtaw_reg_idx_t;

    typedef struct packed {
        logic [15:0] rtt_threshold;
        logic [15:0] holdoff;
        logic [16:0] ewma_weight;
        logic [16:0] dec_factor;
        logic [31:0] min_window;
    } dtaw_cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic ewma_init;
        logic ewma_step;
        logic ewma_fin;
        logic div_init;
        logic div_step;
        logic apply_inc;
        logic mul;
        logic apply_dec;
        logic load_out;
    } dtaw_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic below_thr;
        logic holdoff_ok;
    } dtaw_status_t;

    // Q1.16 factor above one acts as one
    function automatic logic [16:0] clamp_one(input logic [16:0] v);
        return v[16] ? ONE_Q16 : v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/dtaw_ctrl.sv
// ----------------------------------------------------------------------------
// dtaw_ctrl
// Sequencer: accept, EWMA multiply loop, decide, reciprocal division loop,
// decrease multiply or neither, then hand the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtaw_ctrl #(
    parameter int WINDOW_FRAC_BITS = dtaw_pkg::WINDOW_FRAC_BITS_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    input  wire dtaw_pkg::dtaw_status_t status,
    output dtaw_pkg::dtaw_cmd_t  cmd
);
    import dtaw_pkg::*;

    localparam int DIV_STEPS = 2 * WINDOW_FRAC_BITS + 1;
    localparam int MAX_STEPS = (DIV_STEPS > EWMA_STEPS) ? DIV_STEPS : EWMA_STEPS;
    localparam int CNT_W     = $clog2(MAX_STEPS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EWMA_INIT,
        S_EWMA,
        S_EWMA_FIN,
        S_DECIDE,
        S_DIV,
        S_INC,
        S_MUL,
        S_DEC,
        S_FINISH
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               out_valid_reg;
    logic               out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == S_IDLE) && in_valid;
        cmd.ewma_init = (state_reg == S_EWMA_INIT);
        cmd.ewma_step = (state_reg == S_EWMA);
        cmd.ewma_fin  = (state_reg == S_EWMA_FIN);
        cmd.div_init  = (state_reg == S_DECIDE) && status.below_thr;
        cmd.div_step  = (state_reg == S_DIV);
        cmd.apply_inc = (state_reg == S_INC);
        cmd.mul       = (state_reg == S_MUL);
        cmd.apply_dec = (state_reg == S_DEC);
        cmd.load_out  = (state_reg == S_FINISH) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_EWMA_INIT;
                end
                S_EWMA_INIT:
                begin
                    cnt_reg   <= CNT_W'(EWMA_STEPS - 1);
                    state_reg <= S_EWMA;
                end
                S_EWMA:
                begin
                    if (cnt_reg == '0)
                        state_reg <= S_EWMA_FIN;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                S_EWMA_FIN:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (status.below_thr)
                    begin
                        cnt_reg   <= CNT_W'(DIV_STEPS - 1);
                        state_reg <= S_DIV;
                    end
                    else if (status.holdoff_ok)
                        state_reg <= S_MUL;
                    else
                        state_reg <= S_FINISH;
                end
                S_DIV:
                begin
                    if (cnt_reg == '0)
                        state_reg <= S_INC;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                S_INC:
                begin
                    state_reg <= S_FINISH;
                end
                S_MUL:
                begin
                    state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_EWMA_INIT)
        else $error("accepted beat did not start the EWMA");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FINISH)
        else $error("result raised outside the finish state");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && cnt_reg == '0 |=> state_reg == S_INC)
        else $error("division loop overran");

endmodule

`default_nettype wire

>>> rtl/core/dtaw_datapath.sv
// ----------------------------------------------------------------------------
// dtaw_datapath
// RTT sample, EWMA by radix-4 shift-add, restoring reciprocal division,
// decrease multiply with clamp, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtaw_datapath #(
    parameter int TIME_BITS        = dtaw_pkg::TIME_BITS_DEF,
    parameter int WINDOW_FRAC_BITS = dtaw_pkg::WINDOW_FRAC_BITS_DEF
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire dtaw_pkg::dtaw_cmd_t cmd,
    output dtaw_pkg::dtaw_status_t  status,
    input  wire dtaw_pkg::dtaw_cfg_t cfg,
    input  wire [TIME_BITS-1:0]     sent_time_ms,
    input  wire [TIME_BITS-1:0]     ack_time_ms,
    input  wire [TIME_BITS-1:0]     now_ms,
    output logic [15:0]             win_count,
    output logic [31:0]             rtt_estimate_ms,
    output logic                    did_decrease
);
    import dtaw_pkg::*;

    localparam int QW = 2 * WINDOW_FRAC_BITS + 1;
    localparam int SW = ((QW > 32) ? QW : 32) + 1;
    localparam logic [31:0] WIN_ONE = 32'(1) << WINDOW_FRAC_BITS;

    // architectural state
    logic [RTT_W-1:0]       srtt_reg;
    logic                   seen_reg;
    logic [31:0]            win_reg;
    logic [TIME_BITS-1:0]   last_dec_reg;
    logic                   dec_reg;

    // working registers
    logic [31:0]            sample_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] m1_reg;
    logic signed [ACC_W-1:0] m3_reg;
    logic [17:0]            mplier_reg;
    logic [31:0]            rem_reg;
    logic                   lead_reg;
    logic [QW-1:0]          quo_reg;
    logic [48:0]            prod_reg;

    // sample
    logic [TIME_BITS-1:0]   rtt_raw;
    logic [63:0]            rtt_ext;
    logic [31:0]            sample_next;

    assign rtt_raw     = ack_time_ms - sent_time_ms;
    assign rtt_ext     = 64'(rtt_raw);
    assign sample_next = (|rtt_ext[63:32]) ? 32'hFFFF_FFFF : rtt_ext[31:0];

    // EWMA: acc = old<<16 + w*(new - old) + half
    logic signed [40:0]      ew_diff;
    logic signed [ACC_W-1:0] ew_m1;
    logic signed [ACC_W-1:0] ew_m3;
    logic signed [ACC_W-1:0] ew_acc0;
    logic signed [ACC_W-1:0] ew_term;
    logic [RTT_W-1:0]        srtt_next;

    assign ew_diff = $signed({1'b0, sample_reg, 8'b0}) - $signed({1'b0, srtt_reg});
    assign ew_m1   = ACC_W'(ew_diff);
    assign ew_m3   = ew_m1 + (ew_m1 <<< 1);
    assign ew_acc0 = $signed({4'b0, srtt_reg, 16'b0}) + $signed(ACC_W'(32768));

    always_comb
    begin
        case (mplier_reg[1:0])
            2'd1:    ew_term = m1_reg;
            2'd2:    ew_term = m1_reg <<< 1;
            2'd3:    ew_term = m3_reg;
            default: ew_term = '0;
        endcase
    end

    assign srtt_next = seen_reg ? acc_reg[55:16] : {sample_reg, 8'b0};

    // restoring division of 2^(2F) by the window
    logic [32:0] div_t;
    logic        div_ge;
    logic [32:0] div_sub;
    logic [31:0] rem_next;

    assign div_t    = {rem_reg, lead_reg};
    assign div_ge   = div_t >= {1'b0, win_reg};
    assign div_sub  = div_t - {1'b0, win_reg};
    assign rem_next = div_ge ? div_sub[31:0] : div_t[31:0];

    // a zero window goes straight to the top
    logic [SW-1:0] inc_sum;
    logic [31:0]   win_inc_next;

    assign inc_sum      = SW'(win_reg) + SW'(quo_reg);
    assign win_inc_next = ((win_reg == '0) || (|inc_sum[SW-1:32])) ? 32'hFFFF_FFFF
                                                                   : inc_sum[31:0];

    // decrease
    logic [31:0] scaled;
    logic [31:0] win_dec_next;

    assign scaled       = prod_reg[47:16];
    assign win_dec_next = (scaled < cfg.min_window) ? cfg.min_window : scaled;

    // status
    logic [TIME_BITS-1:0] elapsed;

    assign elapsed           = now_reg - last_dec_reg;
    assign status.below_thr  = srtt_reg <= {16'b0, cfg.rtt_threshold, 8'b0};
    assign status.holdoff_ok = elapsed >= TIME_BITS'(cfg.holdoff);

    // output
    logic [31:0] win_int;

    assign win_int = 32'(win_reg >> WINDOW_FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srtt_reg     <= '0;
            seen_reg     <= 1'b0;
            win_reg      <= WIN_ONE;
            last_dec_reg <= '0;
            dec_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                dec_reg <= 1'b0;
            if (cmd.ewma_fin)
            begin
                srtt_reg <= srtt_next;
                seen_reg <= 1'b1;
            end
            if (cmd.apply_inc)
                win_reg <= win_inc_next;
            if (cmd.apply_dec)
            begin
                win_reg      <= win_dec_next;
                last_dec_reg <= now_reg;
                dec_reg      <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample_next;
            now_reg    <= now_ms;
        end
        if (cmd.ewma_init)
        begin
            acc_reg    <= ew_acc0;
            m1_reg     <= ew_m1;
            m3_reg     <= ew_m3;
            mplier_reg <= {1'b0, clamp_one(cfg.ewma_weight)};
        end
        if (cmd.ewma_step)
        begin
            acc_reg    <= acc_reg + ew_term;
            m1_reg     <= m1_reg <<< 2;
            m3_reg     <= m3_reg <<< 2;
            mplier_reg <= mplier_reg >> 2;
        end
        if (cmd.div_init)
        begin
            rem_reg  <= '0;
            lead_reg <= 1'b1;
            quo_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            lead_reg <= 1'b0;
            quo_reg  <= {quo_reg[QW-2:0], div_ge};
        end
        if (cmd.mul)
            prod_reg <= 49'(win_reg) * 49'(clamp_one(cfg.dec_factor));
        if (cmd.load_out)
        begin
            win_count       <= (|win_int[31:16]) ? 16'hFFFF : win_int[15:0];
            rtt_estimate_ms <= srtt_reg[RTT_W-1:RTT_FRAC];
            did_decrease    <= dec_reg;
        end
    end

    a_dec_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply_dec |=> win_reg >= $past(cfg.min_window))
        else $error("window fell below its floor after a decrease");

endmodule

`default_nettype wire

>>> rtl/core/delay_threshold_aimd_window_top.sv
// ----------------------------------------------------------------------------
// delay_threshold_aimd_window_top
// Delay-threshold AIMD congestion window, one update per acknowledgement.
// ----------------------------------------------------------------------------
// One acknowledgement is taken at a time. It passes the EWMA update, a
// decision and then a multiplicative decrease, a growth step or neither
// before its result is loaded; the growth step is a one-bit-per-cycle
// restoring division of 2^(2*F) by the window, and the EWMA update is a
// two-bit shift-add multiplier. The result sits in an output register, so
// the next beat is taken in the cycle after the result is loaded, even while
// it waits to be read. A further result waits in the sequencer until the
// previous one is read. Configuration writes are registered and should be
// made only while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module delay_threshold_aimd_window_top #(
    parameter int TIME_BITS        = dtaw_pkg::TIME_BITS_DEF,
    parameter int WINDOW_FRAC_BITS = dtaw_pkg::WINDOW_FRAC_BITS_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_wr_en,
    input  wire [dtaw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [dtaw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire [TIME_BITS-1:0]             sent_time_ms,
    input  wire [TIME_BITS-1:0]             ack_time_ms,
    input  wire [TIME_BITS-1:0]             now_ms,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [15:0]                     win_count,
    output logic [31:0]                     rtt_estimate_ms,
    output logic                            did_decrease
);
    import dtaw_pkg::*;

    localparam logic [31:0] MIN_WINDOW_RST = 32'(1) << WINDOW_FRAC_BITS;

    dtaw_cfg_t    cfg_reg;
    dtaw_cmd_t    cmd;
    dtaw_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rtt_threshold <= RTT_THRESHOLD_RST;
            cfg_reg.holdoff       <= HOLDOFF_RST;
            cfg_reg.ewma_weight   <= EWMA_WEIGHT_RST;
            cfg_reg.dec_factor    <= DEC_FACTOR_RST;
            cfg_reg.min_window    <= MIN_WINDOW_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_RTT_THRESHOLD: cfg_reg.rtt_threshold <= cfg_data[15:0];
                REG_HOLDOFF:       cfg_reg.holdoff       <= cfg_data[15:0];
                REG_EWMA_WEIGHT:   cfg_reg.ewma_weight   <= cfg_data[16:0];
                REG_DEC_FACTOR:    cfg_reg.dec_factor    <= cfg_data[16:0];
                REG_MIN_WINDOW:    cfg_reg.min_window    <= cfg_data[31:0];
                default:           ;
            endcase
        end
    end

    dtaw_ctrl #(
        .WINDOW_FRAC_BITS (WINDOW_FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dtaw_datapath #(
        .TIME_BITS        (TIME_BITS),
        .WINDOW_FRAC_BITS (WINDOW_FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg             (cfg_reg),
        .sent_time_ms    (sent_time_ms),
        .ack_time_ms     (ack_time_ms),
        .now_ms          (now_ms),
        .win_count       (win_count),
        .rtt_estimate_ms (rtt_estimate_ms),
        .did_decrease    (did_decrease)
    );

endmodule

`default_nettype wire
